FILE: hw/rtl/nzsd_pkg.sv
// Package for the zero-nibble-suppressed stream decoder.
// Holds the shared types, constants and the single-nibble step function.
// No dependencies.
package nzsd_pkg;

  localparam int unsigned PAIR_COUNT_BITS_DEF = 25;
  localparam int unsigned RES_MAX             = 4;
  localparam int unsigned RES_CNT_W           = $clog2(RES_MAX + 1);
  localparam int unsigned RES_IDX_W           = $clog2(RES_MAX);
  localparam logic [3:0]  NIB_MASK            = 4'hf;

  // Group assembly state carried from nibble to nibble.
  typedef struct packed {
    logic        have_key;
    logic [3:0]  key;
    logic [15:0] value;
  } nib_st_t;

  typedef struct packed {
    nib_st_t     st;
    logic        emit;
    logic [15:0] pair;
  } nib_res_t;

  // Results of one input byte, handed from the expander to the output buffer.
  typedef struct packed {
    logic [RES_CNT_W-1:0]      n;
    logic [RES_MAX-1:0][7:0]   bytes;
    logic [RES_MAX-1:0]        done;
  } exp_res_t;

  // Consumes one nibble. A zero key, or the last present nibble of a group,
  // completes the pair and clears the group state.
  function automatic nib_res_t nib_step(nib_st_t s, logic [3:0] nib_in);
    nib_res_t   r;
    logic       found;
    logic [3:0] nib;
    nib   = nib_in & NIB_MASK;
    found = 1'b0;
    r     = '0;
    if (!s.have_key) begin
      if (nib == 4'h0) begin
        r.emit = 1'b1;
        r.pair = 16'h0000;
      end else begin
        r.st.have_key = 1'b1;
        r.st.key      = nib;
        r.st.value    = 16'h0000;
      end
    end else begin
      r.st = s;
      for (int i = 0; i < 4; i++) begin
        if (!found && s.key[i]) begin
          r.st.value[4*i +: 4] = nib;
          r.st.key[i]          = 1'b0;
          found                = 1'b1;
        end
      end
      if (r.st.key == 4'h0) begin
        r.emit = 1'b1;
        r.pair = r.st.value;
        r.st   = '0;
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/nzsd_expand.sv
// Expander: holds the group and pair-count state and turns one compressed
// byte into up to two byte pairs in a single pass. Depends on nzsd_pkg.
module nzsd_expand #(
  parameter int unsigned PAIR_COUNT_BITS = nzsd_pkg::PAIR_COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [7:0]                 comp_byte,
  input  logic [PAIR_COUNT_BITS-1:0] pair_count,
  output nzsd_pkg::exp_res_t         res
);
  import nzsd_pkg::*;

  nib_st_t                    st_r, st_nxt;
  logic [PAIR_COUNT_BITS-1:0] emitted_r, emitted_nxt;
  logic [PAIR_COUNT_BITS-1:0] next_a, next_b, after_lo;
  nib_res_t                   lo, hi;
  logic                       done_lo, done_hi, emit_hi;

  assign next_a = emitted_r + PAIR_COUNT_BITS'(1);
  assign next_b = emitted_r + PAIR_COUNT_BITS'(2);

  always_comb begin
    lo       = nib_step(st_r, comp_byte[3:0]);
    done_lo  = lo.emit && (next_a == pair_count);
    after_lo = lo.emit ? next_a : emitted_r;
    hi       = nib_step(lo.st, comp_byte[7:4]);
    // The high nibble is dropped once the low nibble has ended the stream.
    emit_hi  = hi.emit && !done_lo;
    done_hi  = emit_hi && ((lo.emit ? next_b : next_a) == pair_count);

    if (done_lo) begin
      st_nxt      = '0;
      emitted_nxt = '0;
    end else begin
      st_nxt = hi.st;
      if (done_hi) begin
        emitted_nxt = '0;
      end else if (emit_hi) begin
        emitted_nxt = lo.emit ? next_b : next_a;
      end else begin
        emitted_nxt = after_lo;
      end
    end

    res          = '0;
    res.n        = RES_CNT_W'({1'b0, lo.emit} + {1'b0, emit_hi}) << 1;
    res.bytes[0] = lo.emit ? lo.pair[7:0]  : hi.pair[7:0];
    res.bytes[1] = lo.emit ? lo.pair[15:8] : hi.pair[15:8];
    res.bytes[2] = hi.pair[7:0];
    res.bytes[3] = hi.pair[15:8];
    res.done[1]  = lo.emit ? done_lo : done_hi;
    res.done[3]  = done_hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '0;
      emitted_r <= '0;
    end else if (step_en) begin
      st_r      <= st_nxt;
      emitted_r <= emitted_nxt;
    end
  end

endmodule

FILE: hw/rtl/nzsd_outbuf.sv
// Result buffer: takes all results of one input byte at once and hands them
// out one per transfer. Depends on nzsd_pkg.
module nzsd_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  nzsd_pkg::exp_res_t res,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_run_last,
  output logic               out_stream_done
);
  import nzsd_pkg::*;

  logic [RES_MAX-1:0][7:0]   byte_r;
  logic [RES_MAX-1:0]        done_r;
  logic [RES_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [RES_IDX_W-1:0]      rd_r, rd_nxt;
  logic                      pop;

  assign out_valid       = (cnt_r != '0);
  assign pop             = out_valid && out_ready;
  // A new item may enter when the buffer is empty or empties in this cycle.
  assign can_load        = (cnt_r == '0) || ((cnt_r == RES_CNT_W'(1)) && out_ready);
  assign out_byte        = byte_r[rd_r];
  assign out_stream_done = done_r[rd_r];
  assign out_run_last    = (cnt_r == RES_CNT_W'(1));

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    if (load && can_load) begin
      cnt_nxt = res.n;
      rd_nxt  = '0;
    end else if (pop) begin
      cnt_nxt = cnt_r - RES_CNT_W'(1);
      rd_nxt  = rd_r + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      byte_r <= res.bytes;
      done_r <= res.done;
    end
  end

endmodule

FILE: hw/rtl/nibble_zero_suppress_decoder.sv
// An accepted byte passes the input register and then the result buffer register before
// its first output byte is valid; a new byte can enter while results are still going out.
// Each input byte yields N = 0, 2 or 4 output bytes, handed out one per transfer on the
// byte-wide output port; a stalled output holds the input back until the buffer drains.
// Reset (rst_n low, synchronous) empties all stages, clears the group and pair counter,
// and sets pair_count to 1. Depends on nzsd_pkg, nzsd_expand and nzsd_outbuf.
module nibble_zero_suppress_decoder #(
  parameter int unsigned PAIR_COUNT_BITS = nzsd_pkg::PAIR_COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [PAIR_COUNT_BITS-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_comp_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_run_last,
  output logic                       out_stream_done
);
  import nzsd_pkg::*;

  logic [PAIR_COUNT_BITS-1:0] pair_count_r;
  logic                       s1_valid_r;
  logic [7:0]                 s1_byte_r;
  logic                       can_load;
  logic                       s1_take;
  exp_res_t                   res;

  // Always ready; the user must write the pair count only while idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_count_r <= PAIR_COUNT_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      pair_count_r <= cfg_data;
    end
  end

  // The input register drains into the result buffer whenever the buffer is empty
  // or about to empty, so a new byte can follow in the next cycle while the
  // last result of the previous one is still being transferred.
  assign s1_take  = s1_valid_r && can_load;
  assign in_ready = !s1_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_comp_byte;
    end
  end

  // The expander advances its group state exactly when the registered byte
  // is handed to the result buffer.
  nzsd_expand #(
    .PAIR_COUNT_BITS(PAIR_COUNT_BITS)
  ) u_expand (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_take),
    .comp_byte (s1_byte_r),
    .pair_count(pair_count_r),
    .res       (res)
  );

  nzsd_outbuf u_outbuf (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (s1_valid_r),
    .res            (res),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_stream_done(out_stream_done)
  );

`ifndef SYNTHESIS
  // The end of a stream drops the rest of the byte, so it is always the last result.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_run_last)
    else $error("stream end is not the last result of its byte");

  // An empty input register never blocks the input channel.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with an empty input register");

  // A held byte stays in place until the buffer takes it.
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !can_load |=> s1_valid_r && $stable(s1_byte_r))
    else $error("registered byte lost while the buffer was busy");
`endif

endmodule
